[rtl/core/kwrfe_pkg.sv]
// Shared types and constants for the keyword record field extractor.
package kwrfe_pkg;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WORD,
    PH_GAP,
    PH_VALUE,
    PH_SKIP,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VALUE,
    KIND_RECORD,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    FLD_NAME,
    FLD_ACC,
    FLD_LENG,
    FLD_ALPH
  } field_t;

  typedef enum logic [1:0] {
    ERR_BLANK_LINE,
    ERR_NO_VALUE,
    ERR_FIELD_MISSING,
    ERR_NO_END_MARK
  } err_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // First words packed as the last four bytes seen, oldest in the top byte
  localparam logic [31:0] W_NAME = 32'h4E41_4D45;
  localparam logic [31:0] W_ACC  = 32'h0041_4343;
  localparam logic [31:0] W_LENG = 32'h4C45_4E47;
  localparam logic [31:0] W_ALPH = 32'h414C_5048;
  localparam logic [31:0] W_END  = 32'h0000_2F2F;

  localparam logic [2:0] WORD_LEN_2   = 3'd2;
  localparam logic [2:0] WORD_LEN_3   = 3'd3;
  localparam logic [2:0] WORD_LEN_4   = 3'd4;
  localparam logic [2:0] WORD_LEN_SAT = 3'd5;

  typedef struct packed {
    kind_t       kind;
    field_t      field_tag;
    logic        first_of_field;
    logic [7:0]  value_byte;
    logic [10:0] name_count;
    logic [4:0]  acc_count;
    logic [3:0]  leng_count;
    logic [3:0]  alph_count;
    logic        overflowed;
    err_t        error_code;
  } res_t;

endpackage

[rtl/core/keyword_record_field_extractor_unit.sv]
// Keyword record field extractor: top level with input and result registers.
// Takes one text byte per cycle while the result register is not stalled and
// returns at most one result per byte. Each request passes an input register,
// one step of the line parser and a result register; the parser steps on a
// byte, and its result is loaded into the result register, only when that
// register is free. The parser state is updated once per byte, which sets the
// rate at one byte per clock; a stalled result register holds the input
// register, which then stalls the input channel. No clearing pass follows reset.
module keyword_record_field_extractor_unit #(
  parameter int NAME_CAP = 1024,
  parameter int ACC_CAP  = 16,
  parameter int LENG_CAP = 8,
  parameter int ALPH_CAP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_field_tag,
  output logic        out_first_of_field,
  output logic [7:0]  out_value_byte,
  output logic [10:0] out_name_count,
  output logic [4:0]  out_acc_count,
  output logic [3:0]  out_leng_count,
  output logic [3:0]  out_alph_count,
  output logic        out_overflowed,
  output logic [1:0]  out_error_code
);

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_byte_r, s1_byte_nxt;
  logic            s1_end_r, s1_end_nxt;
  logic            out_valid_r, out_valid_nxt;
  kwrfe_pkg::res_t out_res_r, out_res_nxt;

  logic            out_free;
  logic            s1_fire;
  logic            core_valid;
  kwrfe_pkg::res_t core_res;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  kwrfe_core #(
    .NAME_CAP (NAME_CAP),
    .ACC_CAP  (ACC_CAP),
    .LENG_CAP (LENG_CAP),
    .ALPH_CAP (ALPH_CAP)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_fire),
    .text_byte  (s1_byte_r),
    .stream_end (s1_end_r),
    .res_valid  (core_valid),
    .res        (core_res)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_byte_nxt   = s1_byte_r;
    s1_end_nxt    = s1_end_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    // Load the next request whenever the input register is free or draining
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      if (in_valid) begin
        s1_byte_nxt = in_text_byte;
        s1_end_nxt  = in_stream_end;
      end
    end
    if (out_free) begin
      out_valid_nxt = s1_fire && core_valid;
      if (s1_fire && core_valid) out_res_nxt = core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    s1_end_r  <= s1_end_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_field_tag      = out_res_r.field_tag;
  assign out_first_of_field = out_res_r.first_of_field;
  assign out_value_byte     = out_res_r.value_byte;
  assign out_name_count     = out_res_r.name_count;
  assign out_acc_count      = out_res_r.acc_count;
  assign out_leng_count     = out_res_r.leng_count;
  assign out_alph_count     = out_res_r.alph_count;
  assign out_overflowed     = out_res_r.overflowed;
  assign out_error_code     = out_res_r.error_code;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_byte_r) &&
    $stable(s1_end_r))
    else $error("pending request lost while results stalled");

  a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && core_valid |=> out_valid_r && out_res_r == $past(core_res))
    else $error("parser result not captured");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result changed");

endmodule

[rtl/core/kwrfe_core.sv]
// Line parser state and per-byte step logic for the keyword record field extractor.
module kwrfe_core #(
  parameter int NAME_CAP = 1024,
  parameter int ACC_CAP  = 16,
  parameter int LENG_CAP = 8,
  parameter int ALPH_CAP = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       text_byte,
  input  logic             stream_end,
  output logic             res_valid,
  output kwrfe_pkg::res_t  res
);

  localparam int NLW = $clog2(NAME_CAP + 1);
  localparam int ALW = $clog2(ACC_CAP + 1);
  localparam int LLW = $clog2(LENG_CAP + 1);
  localparam int PLW = $clog2(ALPH_CAP + 1);

  kwrfe_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]       chars_r, chars_nxt;
  logic [2:0]        count_r, count_nxt;
  kwrfe_pkg::field_t field_r, field_nxt;
  logic [NLW-1:0]    name_len_r, name_len_nxt;
  logic [ALW-1:0]    acc_len_r, acc_len_nxt;
  logic [LLW-1:0]    leng_len_r, leng_len_nxt;
  logic [PLW-1:0]    alph_len_r, alph_len_nxt;
  logic              cut_r, cut_nxt;
  logic              last_end_r, last_end_nxt;

  logic              is_name, is_acc, is_leng, is_alph, is_end;
  logic              is_sp, is_nl;
  logic              store_en, store_first;
  kwrfe_pkg::field_t kw_field;

  assign is_sp   = (text_byte == kwrfe_pkg::CH_SPACE);
  assign is_nl   = (text_byte == kwrfe_pkg::CH_NL);
  assign is_name = (count_r == kwrfe_pkg::WORD_LEN_4) && (chars_r == kwrfe_pkg::W_NAME);
  assign is_acc  = (count_r == kwrfe_pkg::WORD_LEN_3) && (chars_r == kwrfe_pkg::W_ACC);
  assign is_leng = (count_r == kwrfe_pkg::WORD_LEN_4) && (chars_r == kwrfe_pkg::W_LENG);
  assign is_alph = (count_r == kwrfe_pkg::WORD_LEN_4) && (chars_r == kwrfe_pkg::W_ALPH);
  assign is_end  = (count_r == kwrfe_pkg::WORD_LEN_2) && (chars_r == kwrfe_pkg::W_END);

  always_comb begin
    priority if (is_name) kw_field = kwrfe_pkg::FLD_NAME;
    else if (is_acc)      kw_field = kwrfe_pkg::FLD_ACC;
    else if (is_leng)     kw_field = kwrfe_pkg::FLD_LENG;
    else                  kw_field = kwrfe_pkg::FLD_ALPH;
  end

  always_comb begin
    phase_nxt    = phase_r;
    chars_nxt    = chars_r;
    count_nxt    = count_r;
    field_nxt    = field_r;
    name_len_nxt = name_len_r;
    acc_len_nxt  = acc_len_r;
    leng_len_nxt = leng_len_r;
    alph_len_nxt = alph_len_r;
    cut_nxt      = cut_r;
    last_end_nxt = last_end_r;
    store_en     = 1'b0;
    store_first  = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    if (step_en && stream_end) begin
      if (phase_r != kwrfe_pkg::PH_ERROR && !last_end_r) begin
        res_valid      = 1'b1;
        res.kind       = kwrfe_pkg::KIND_ERROR;
        res.error_code = kwrfe_pkg::ERR_NO_END_MARK;
      end
      phase_nxt    = kwrfe_pkg::PH_LEAD;
      chars_nxt    = '0;
      count_nxt    = '0;
      field_nxt    = kwrfe_pkg::FLD_NAME;
      name_len_nxt = '0;
      acc_len_nxt  = '0;
      leng_len_nxt = '0;
      alph_len_nxt = '0;
      cut_nxt      = 1'b0;
      last_end_nxt = 1'b0;
    end else if (step_en) begin
      unique case (phase_r)
        kwrfe_pkg::PH_LEAD: begin
          if (is_nl) begin
            res_valid      = 1'b1;
            res.kind       = kwrfe_pkg::KIND_ERROR;
            res.error_code = kwrfe_pkg::ERR_BLANK_LINE;
            phase_nxt      = kwrfe_pkg::PH_ERROR;
          end else if (!is_sp) begin
            last_end_nxt = 1'b0;
            chars_nxt    = {24'h0, text_byte};
            count_nxt    = 3'd1;
            phase_nxt    = kwrfe_pkg::PH_WORD;
          end
        end
        kwrfe_pkg::PH_WORD: begin
          if (!is_sp && !is_nl) begin
            chars_nxt = {chars_r[23:0], text_byte};
            if (count_r < kwrfe_pkg::WORD_LEN_SAT) count_nxt = count_r + 3'd1;
          end else if (is_name || is_acc || is_leng || is_alph) begin
            if (is_nl) begin
              res_valid      = 1'b1;
              res.kind       = kwrfe_pkg::KIND_ERROR;
              res.error_code = kwrfe_pkg::ERR_NO_VALUE;
              phase_nxt      = kwrfe_pkg::PH_ERROR;
            end else begin
              field_nxt = kw_field;
              phase_nxt = kwrfe_pkg::PH_GAP;
            end
          end else begin
            phase_nxt = is_nl ? kwrfe_pkg::PH_LEAD : kwrfe_pkg::PH_SKIP;
            if (is_end) begin
              last_end_nxt = 1'b1;
              res_valid    = 1'b1;
              if (name_len_r == '0 || acc_len_r == '0 || leng_len_r == '0 ||
                  alph_len_r == '0) begin
                res.kind       = kwrfe_pkg::KIND_ERROR;
                res.error_code = kwrfe_pkg::ERR_FIELD_MISSING;
                phase_nxt      = kwrfe_pkg::PH_ERROR;
              end else begin
                res.kind       = kwrfe_pkg::KIND_RECORD;
                res.name_count = 11'(name_len_r);
                res.acc_count  = 5'(acc_len_r);
                res.leng_count = 4'(leng_len_r);
                res.alph_count = 4'(alph_len_r);
                res.overflowed = cut_r;
                name_len_nxt   = '0;
                acc_len_nxt    = '0;
                leng_len_nxt   = '0;
                alph_len_nxt   = '0;
                cut_nxt        = 1'b0;
              end
            end
          end
        end
        kwrfe_pkg::PH_GAP: begin
          if (is_nl) begin
            res_valid      = 1'b1;
            res.kind       = kwrfe_pkg::KIND_ERROR;
            res.error_code = kwrfe_pkg::ERR_NO_VALUE;
            phase_nxt      = kwrfe_pkg::PH_ERROR;
          end else if (!is_sp) begin
            phase_nxt   = kwrfe_pkg::PH_VALUE;
            store_en    = 1'b1;
            store_first = 1'b1;
          end
        end
        kwrfe_pkg::PH_VALUE: begin
          if (is_nl) phase_nxt = kwrfe_pkg::PH_LEAD;
          else store_en = 1'b1;
        end
        kwrfe_pkg::PH_SKIP: begin
          if (is_nl) phase_nxt = kwrfe_pkg::PH_LEAD;
        end
        kwrfe_pkg::PH_ERROR: begin
        end
        default: begin
          phase_nxt = kwrfe_pkg::PH_ERROR;
        end
      endcase

      // Append the value byte, or drop it and flag the cut once the field is full
      if (store_en) begin
        res.kind           = kwrfe_pkg::KIND_VALUE;
        res.field_tag      = field_r;
        res.first_of_field = store_first;
        res.value_byte     = text_byte;
        unique case (field_r)
          kwrfe_pkg::FLD_NAME: begin
            if (!store_first && name_len_r >= NLW'(NAME_CAP)) cut_nxt = 1'b1;
            else begin
              res_valid    = 1'b1;
              name_len_nxt = store_first ? NLW'(1) : name_len_r + NLW'(1);
            end
          end
          kwrfe_pkg::FLD_ACC: begin
            if (!store_first && acc_len_r >= ALW'(ACC_CAP)) cut_nxt = 1'b1;
            else begin
              res_valid   = 1'b1;
              acc_len_nxt = store_first ? ALW'(1) : acc_len_r + ALW'(1);
            end
          end
          kwrfe_pkg::FLD_LENG: begin
            if (!store_first && leng_len_r >= LLW'(LENG_CAP)) cut_nxt = 1'b1;
            else begin
              res_valid    = 1'b1;
              leng_len_nxt = store_first ? LLW'(1) : leng_len_r + LLW'(1);
            end
          end
          kwrfe_pkg::FLD_ALPH: begin
            if (!store_first && alph_len_r >= PLW'(ALPH_CAP)) cut_nxt = 1'b1;
            else begin
              res_valid    = 1'b1;
              alph_len_nxt = store_first ? PLW'(1) : alph_len_r + PLW'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= kwrfe_pkg::PH_LEAD;
      chars_r    <= '0;
      count_r    <= '0;
      field_r    <= kwrfe_pkg::FLD_NAME;
      name_len_r <= '0;
      acc_len_r  <= '0;
      leng_len_r <= '0;
      alph_len_r <= '0;
      cut_r      <= 1'b0;
      last_end_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      chars_r    <= chars_nxt;
      count_r    <= count_nxt;
      field_r    <= field_nxt;
      name_len_r <= name_len_nxt;
      acc_len_r  <= acc_len_nxt;
      leng_len_r <= leng_len_nxt;
      alph_len_r <= alph_len_nxt;
      cut_r      <= cut_nxt;
      last_end_r <= last_end_nxt;
    end
  end

  a_len_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    name_len_r <= NLW'(NAME_CAP) && acc_len_r <= ALW'(ACC_CAP) &&
    leng_len_r <= LLW'(LENG_CAP) && alph_len_r <= PLW'(ALPH_CAP))
    else $error("field length above its capacity");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && stream_end |=> phase_r == kwrfe_pkg::PH_LEAD && !last_end_r &&
    !cut_r && name_len_r == '0 && acc_len_r == '0)
    else $error("state not cleared after end of stream");

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !stream_end && phase_r == kwrfe_pkg::PH_ERROR |-> !res_valid)
    else $error("result produced while in sticky error");

endmodule
